@@ design/uri_percent_decode_dot_strip_unit_macros.svh @@
// Assertion macros shared by the URI percent-decode unit.
`ifndef URI_PERCENT_DECODE_DOT_STRIP_UNIT_MACROS_SVH
`define URI_PERCENT_DECODE_DOT_STRIP_UNIT_MACROS_SVH

// Same-cycle implication, off during reset
`define UPDDS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("updds check failed");

// Next-cycle implication, off during reset
`define UPDDS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("updds check failed");

`endif

@@ design/updds_pkg.sv @@
// Shared constants, job type and hex helpers for the URI percent-decode unit.
package updds_pkg;

    localparam logic [7:0] ChPercent = 8'h25;
    localparam logic [7:0] ChW       = 8'h57;
    localparam logic [7:0] ChZero    = 8'h30;
    localparam logic [7:0] ChNine    = 8'h39;
    localparam logic [7:0] ChLowA    = 8'h61;
    localparam logic [7:0] ChLowF    = 8'h66;
    localparam logic [7:0] ChCase    = 8'h20;
    localparam logic [7:0] ChDot     = 8'h2E;
    localparam logic [7:0] ChSlash   = 8'h2F;
    localparam logic [7:0] ChBslash  = 8'h5C;

    // Candidate bytes one input byte can produce before filtering
    localparam int JobSlots = 3;

    typedef struct packed {
        logic [1:0]                cnt;
        logic [JobSlots-1:0][7:0]  bytes;
        logic                      last;
    } t_job;

    function automatic logic is_hex(input logic [7:0] c);
        logic [7:0] l;
        l = c | ChCase;
        return ((c >= ChZero) && (c <= ChNine)) || ((l >= ChLowA) && (l <= ChLowF));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] t;
        t = (c | ChCase) - ChW;
        if ((c >= ChZero) && (c <= ChNine)) begin
            return c[3:0];
        end
        return t[3:0];
    endfunction

endpackage

@@ design/updds_front.sv @@
// Front end: escape parsing, turns each request into a job of candidate bytes.
module updds_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  logic [7:0]           i_in_byte,
    input  logic                 i_in_last,
    output updds_pkg::t_job      o_job
);

    localparam logic [1:0] EscIdle  = 2'd0;
    localparam logic [1:0] EscPct   = 2'd1;
    localparam logic [1:0] EscDigit = 2'd2;

    logic [1:0] r_stage, n_stage;
    logic [7:0] r_held, n_held;

    // Decode the escape state and collect candidate bytes
    always_comb begin
        updds_pkg::t_job job;
        logic [1:0]      idx;
        logic            fresh;
        logic            hex;
        job     = '0;
        idx     = 2'd0;
        fresh   = 1'b0;
        hex     = updds_pkg::is_hex(i_in_byte);
        n_stage = EscIdle;
        n_held  = r_held;
        unique case (r_stage)
            EscPct: begin
                if (hex) begin
                    n_held  = i_in_byte;
                    n_stage = EscDigit;
                end else begin
                    job.bytes[idx] = updds_pkg::ChPercent;
                    idx = idx + 2'd1;
                    fresh = 1'b1;
                end
            end
            EscDigit: begin
                if (hex) begin
                    job.bytes[idx] = {updds_pkg::hex_val(r_held),
                                      updds_pkg::hex_val(i_in_byte)};
                    idx = idx + 2'd1;
                end else begin
                    job.bytes[idx] = updds_pkg::ChPercent;
                    idx = idx + 2'd1;
                    job.bytes[idx] = r_held;
                    idx = idx + 2'd1;
                    fresh = 1'b1;
                end
            end
            default: begin
                fresh = 1'b1;
            end
        endcase
        // Handle the current byte afresh
        if (fresh) begin
            if (i_in_byte == updds_pkg::ChPercent) begin
                n_stage = EscPct;
            end else begin
                job.bytes[idx] = i_in_byte;
                idx = idx + 2'd1;
            end
        end
        // Flush a pending escape at the end of the URI
        if (i_in_last) begin
            if (n_stage == EscPct) begin
                job.bytes[idx] = updds_pkg::ChPercent;
                idx = idx + 2'd1;
            end else if (n_stage == EscDigit) begin
                job.bytes[idx] = updds_pkg::ChPercent;
                idx = idx + 2'd1;
                job.bytes[idx] = n_held;
                idx = idx + 2'd1;
            end
            n_stage = EscIdle;
            n_held  = 8'd0;
        end
        job.cnt  = idx;
        job.last = i_in_last;
        o_job    = job;
    end

    // Advance escape state on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= EscIdle;
            r_held  <= 8'd0;
        end else if (i_wr) begin
            r_stage <= n_stage;
            r_held  <= n_held;
        end
    end

endmodule

@@ design/updds_jobq.sv @@
// Two-entry job queue between front end and back end.
module updds_jobq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  updds_pkg::t_job      i_job,
    output logic                 o_full,
    input  logic                 i_rd,
    output logic                 o_valid,
    output updds_pkg::t_job      o_job
);

    updds_pkg::t_job r_mem [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    // Store jobs
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wp <= ~r_wp;
            end
            if (i_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end

endmodule

@@ design/updds_back.sv @@
// Back end: separator filter, zero-byte stop, and result drain.
`include "uri_percent_decode_dot_strip_unit_macros.svh"

module updds_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    input  updds_pkg::t_job      i_q_job,
    output logic                 o_q_rd,
    input  logic                 i_pop,
    output logic                 o_empty,
    output logic [7:0]           o_out_byte,
    output logic                 o_byte_valid,
    output logic                 o_out_last
);

    logic                                 r_sep, n_sep;
    logic                                 r_stop, n_stop;
    logic [updds_pkg::JobSlots-1:0][7:0]  r_ent, n_ent;
    logic                                 r_marker, n_marker;
    logic                                 r_last;
    logic [1:0]                           r_dcnt, n_dcnt;
    logic [1:0]                           r_didx;
    logic                                 pop_now;
    logic                                 final_ent;
    logic                                 drain_free;

    assign o_empty    = (r_dcnt == 2'd0);
    assign pop_now    = i_pop && !o_empty;
    assign final_ent  = (r_didx == (r_dcnt - 2'd1));
    assign drain_free = o_empty || (pop_now && final_ent);
    assign o_q_rd     = i_q_valid && drain_free;

    assign o_out_byte   = r_marker ? 8'd0 : r_ent[r_didx];
    assign o_byte_valid = !r_marker;
    assign o_out_last   = r_last && final_ent;

    // Filter the queue head job into a list of results
    always_comb begin
        logic       sep;
        logic       stop;
        logic [1:0] n;
        logic [7:0] d;
        sep   = r_sep;
        stop  = r_stop;
        n     = 2'd0;
        d     = 8'd0;
        n_ent = '0;
        for (int k = 0; k < updds_pkg::JobSlots; k++) begin
            if (k < int'(i_q_job.cnt)) begin
                d = i_q_job.bytes[k];
                if (!stop) begin
                    if (d == 8'd0) begin
                        stop = 1'b1;
                    end else if (sep && ((d == updds_pkg::ChDot) ||
                                         (d == updds_pkg::ChSlash) ||
                                         (d == updds_pkg::ChBslash))) begin
                        sep = sep;
                    end else begin
                        sep = (d == updds_pkg::ChSlash) || (d == updds_pkg::ChBslash);
                        n_ent[n] = d;
                        n = n + 2'd1;
                    end
                end
            end
        end
        n_marker = i_q_job.last && (n == 2'd0);
        n_dcnt   = n_marker ? 2'd1 : n;
        // Reopen the filter for the next URI
        n_sep    = i_q_job.last ? 1'b0 : sep;
        n_stop   = i_q_job.last ? 1'b0 : stop;
    end

    // Hold payload of the drain register
    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_ent    <= n_ent;
            r_marker <= n_marker;
            r_last   <= i_q_job.last;
        end
    end

    // Advance filter state and drain position; a new job load takes priority
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep  <= 1'b0;
            r_stop <= 1'b0;
            r_dcnt <= 2'd0;
            r_didx <= 2'd0;
        end else if (o_q_rd) begin
            r_sep  <= n_sep;
            r_stop <= n_stop;
            r_dcnt <= n_dcnt;
            r_didx <= 2'd0;
        end else if (pop_now) begin
            if (final_ent) begin
                r_dcnt <= 2'd0;
                r_didx <= 2'd0;
            end else begin
                r_didx <= r_didx + 2'd1;
            end
        end
    end

    `UPDDS_ASSERT_NOW(a_idx_in_range, r_dcnt != 2'd0, r_didx < r_dcnt)
    `UPDDS_ASSERT_NOW(a_marker_alone, (r_dcnt != 2'd0) && r_marker, (r_dcnt == 2'd1) && r_last)
    `UPDDS_ASSERT_NEXT(a_pop_advances, pop_now && !final_ent, r_didx == ($past(r_didx) + 2'd1))

endmodule

@@ design/uri_percent_decode_dot_strip_unit.sv @@
// A request is written into the job queue, then loaded into the drain register, where its first result shows.
// Throughput: one request per cycle while full is low; results drain one per pop, so
//   a request's two or three results (flushed escapes) hold the back end until popped.
// A two-entry job queue decouples the escape parser from the filter and result drain.
// Reset: synchronous, active low; clears escape, filter and queue state, no results.
// The result register itself is the output, emptied by pop.
module uri_percent_decode_dot_strip_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_in_last,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_out_last
);

    logic            wr;
    logic            q_rd;
    logic            q_valid;
    updds_pkg::t_job f_job;
    updds_pkg::t_job q_job;

    assign wr = push && !full;

    updds_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_job     (f_job)
    );

    updds_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_job   (f_job),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    updds_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_valid    (q_valid),
        .i_q_job      (q_job),
        .o_q_rd       (q_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_out_last   (o_out_last)
    );

endmodule
